### hw/rtl/windowed_rate_of_change_top_macros.svh
// Assertion macros for the windowed rate-of-change checker.
// Expects signals named clk and rst in the scope where the macros are used.
`ifndef WINDOWED_RATE_OF_CHANGE_TOP_MACROS_SVH
`define WINDOWED_RATE_OF_CHANGE_TOP_MACROS_SVH

// same-cycle implication
`define WROC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wroc assertion failed");

// next-cycle implication
`define WROC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wroc assertion failed");

`endif

### hw/rtl/wroc_pkg.sv
// Shared types and constants for the windowed rate-of-change block.
// No dependencies.
package wroc_pkg;

  localparam int VAL_W      = 48;
  localparam int RATE_W     = 56;
  localparam int SLOTS_W    = 7;
  localparam int SLOTS_MIN  = 2;
  localparam int SCALE_W    = 20;
  localparam logic [SCALE_W-1:0] SCALE_MUL = 20'd1000000;
  localparam int FRAC_BITS  = 8;
  localparam int HALF_W     = VAL_W / 2;
  localparam int PART_W     = HALF_W + SCALE_W;
  localparam int PROD_W     = VAL_W + SCALE_W;
  localparam int DIVD_W     = PROD_W + FRAC_BITS;
  localparam int DIV_STEPS  = RATE_W;
  localparam int TOP_W      = DIVD_W - RATE_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int MAX_INFLIGHT = 5;

  localparam int APB_ADDR_W = 2;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW_SLOTS = 2'd0;

  typedef struct packed {
    logic [VAL_W-1:0] dv;
    logic [VAL_W-1:0] dt;
    logic             zero;
  } wroc_job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } wroc_state_t;

endpackage

### hw/rtl/wroc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wroc_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/wroc_front.sv
// Front end: accepts samples, keeps the sample ring and window bookkeeping,
// and hands value/time differences to the queue. Uses wroc_pkg, wroc_ram.
module wroc_front import wroc_pkg::*; #(
  parameter int MAX_SLOTS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [$clog2(MAX_SLOTS+1)-1:0]   slots,
  input  logic                             restart,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [VAL_W-1:0]                 sample_time_us,
  input  logic [VAL_W-1:0]                 sample_value,
  output logic                             push,
  output wroc_job_t                        push_job,
  input  logic                             q_full
);

  localparam int AW = $clog2(MAX_SLOTS);
  localparam int SW = $clog2(MAX_SLOTS + 1);

  logic [AW-1:0]    wp, wp_next;
  logic [SW-1:0]    fill, fill_next;
  logic [VAL_W-1:0] first_t, first_v;
  logic             b_valid, b_first;
  logic [VAL_W-1:0] b_t, b_v;

  logic             accept;
  logic             use_first;
  logic [AW-1:0]    back_dist, old_idx;
  logic [AW:0]      old_wrap;
  logic [2*VAL_W-1:0] rd_data;
  logic [VAL_W-1:0] t_old, v_old, dt;

  assign in_stall = b_valid && q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    fill_next = (fill < slots) ? SW'(fill + 1'b1) : slots;
    use_first = fill_next < slots;
    wp_next   = (wp == AW'(MAX_SLOTS - 1)) ? '0 : AW'(wp + 1'b1);
    back_dist = AW'(slots - 1'b1);
    old_wrap  = (AW+1)'(wp) + (AW+1)'(MAX_SLOTS) - (AW+1)'(back_dist);
    old_idx   = (wp >= back_dist) ? AW'(wp - back_dist) : old_wrap[AW-1:0];
  end

  wroc_ram #(
    .WIDTH (2 * VAL_W),
    .DEPTH (MAX_SLOTS)
  ) u_ring (
    .clk   (clk),
    .we    (accept),
    .waddr (wp),
    .wdata ({sample_time_us, sample_value}),
    .re    (accept),
    .raddr (old_idx),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      fill    <= '0;
      first_t <= '0;
      first_v <= '0;
      b_valid <= 1'b0;
    end else begin
      if (restart) begin
        wp   <= '0;
        fill <= '0;
      end else if (accept) begin
        wp   <= wp_next;
        fill <= fill_next;
      end
      if (accept && fill == '0) begin
        first_t <= sample_time_us;
        first_v <= sample_value;
      end
      b_valid <= accept || (b_valid && !push);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_t     <= sample_time_us;
      b_v     <= sample_value;
      b_first <= use_first;
    end
  end

  // oldest entry: first sample until the window has filled
  always_comb begin
    t_old         = b_first ? first_t : rd_data[2*VAL_W-1:VAL_W];
    v_old         = b_first ? first_v : rd_data[VAL_W-1:0];
    dt            = b_t - t_old;
    push          = b_valid && !q_full;
    push_job.dt   = dt;
    push_job.dv   = b_v - v_old;
    push_job.zero = (dt == '0) || (b_v < v_old);
  end

endmodule

### hw/rtl/wroc_queue.sv
// Short FIFO of difference jobs between front and back ends.
// Uses wroc_pkg.
module wroc_queue import wroc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  wroc_job_t push_job,
  output logic      full,
  input  logic      pop,
  output wroc_job_t pop_job,
  output logic      empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  wroc_job_t       entries [QUEUE_DEPTH];
  logic [PW-1:0]   rd_ptr, wr_ptr;
  logic [CW-1:0]   count;

  assign full    = count == CW'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign pop_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CW'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

### hw/rtl/wroc_back.sv
// Back end: scales the value difference by 256e6 and divides by the time
// span one quotient bit per cycle; owns the output register. Uses wroc_pkg.
module wroc_back import wroc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  wroc_job_t         pop_job,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [RATE_W-1:0] rate,
  output logic              rate_zeroed
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  wroc_state_t        state, state_next;
  logic [VAL_W-1:0]   dv, dt;
  logic [PART_W-1:0]  prod_lo, prod_hi;
  logic [DIVD_W-1:0]  dividend;
  logic [VAL_W-1:0]   rem;
  logic [CNT_W-1:0]   cnt;
  logic [RATE_W-1:0]  res_rate;
  logic               res_zero;

  logic               load_out;
  logic               top_sat;
  logic [VAL_W:0]     trial;
  logic               ge;

  assign top_sat = {{(VAL_W-TOP_W){1'b0}}, dividend[DIVD_W-1:RATE_W]} >= dt;
  assign trial   = {rem, dividend[RATE_W-1]};
  assign ge      = trial >= {1'b0, dt};

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (!q_empty) begin
                   state_next = pop_job.zero ? ST_DONE : ST_MUL_LO;
                 end
      ST_MUL_LO: state_next = ST_MUL_HI;
      ST_MUL_HI: state_next = ST_SUM;
      ST_SUM:    state_next = ST_CHECK;
      ST_CHECK:  state_next = top_sat ? ST_DONE : ST_DIV;
      ST_DIV:    if (cnt == CNT_W'(DIV_STEPS - 1)) begin
                   state_next = ST_DONE;
                 end
      ST_DONE:   if (load_out) begin
                   state_next = ST_IDLE;
                 end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_IDLE: pop      = !q_empty;
      ST_DONE: load_out = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= load_out || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          dv       <= pop_job.dv;
          dt       <= pop_job.dt;
          res_zero <= pop_job.zero;
          res_rate <= '0;
        end
      end
      ST_MUL_LO: prod_lo <= PART_W'(dv[HALF_W-1:0]) * PART_W'(SCALE_MUL);
      ST_MUL_HI: prod_hi <= PART_W'(dv[VAL_W-1:HALF_W]) * PART_W'(SCALE_MUL);
      ST_SUM: begin
        dividend <= {PROD_W'({prod_hi, {HALF_W{1'b0}}}) + PROD_W'(prod_lo),
                     {FRAC_BITS{1'b0}}};
      end
      ST_CHECK: begin
        // quotient reaches 2^56 exactly when the top bits alone cover dt
        if (top_sat) begin
          res_rate <= '1;
        end else begin
          rem      <= VAL_W'(dividend[DIVD_W-1:RATE_W]);
          res_rate <= '0;
          cnt      <= '0;
        end
      end
      ST_DIV: begin
        rem      <= ge ? VAL_W'(trial - {1'b0, dt}) : trial[VAL_W-1:0];
        res_rate <= {res_rate[RATE_W-2:0], ge};
        dividend <= {dividend[DIVD_W-2:0], 1'b0};
        cnt      <= CNT_W'(cnt + 1'b1);
      end
      default: ;
    endcase
    if (load_out) begin
      rate        <= res_rate;
      rate_zeroed <= res_zero;
    end
  end

endmodule

### hw/rtl/windowed_rate_of_change_top.sv
// Windowed rate-of-change estimator, top level.
// Input channel: sample_time_us / sample_value with in_valid / in_stall.
// Output channel: rate (8 fraction bits, units per second) and rate_zeroed
// with out_valid / out_stall. One result per accepted sample, in order.
// Config: APB register window_slots at byte address 0 (clamped to
// 2..MAX_SLOTS); a write restarts the window so the next sample fills it.
// With the back end idle, a sample goes from the front's holding register
// via the queue to the back end: MUL_LO, MUL_HI, SUM, CHECK, the divide,
// DONE; a saturating quotient skips the divide, and a zero span or negative
// difference goes straight to DONE. The back end takes one sample at a time;
// its divider retires one quotient bit per cycle over 56 steps plus setup.
// A two-entry queue and the front's holding register let a few samples be
// taken while the divider is busy; in_stall rises when both are full.
// Reset clears the window, sets window_slots to 2 and empties the pipeline.
// While out_stall is high the result holds and the divider waits in its
// final state; the front keeps filling the queue until it is full.
// Uses wroc_pkg, wroc_front, wroc_queue, wroc_back.
module windowed_rate_of_change_top import wroc_pkg::*; #(
  parameter int MAX_SLOTS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VAL_W-1:0]      sample_time_us,
  input  logic [VAL_W-1:0]      sample_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [RATE_W-1:0]     rate,
  output logic                  rate_zeroed,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int SW    = $clog2(MAX_SLOTS + 1);
  localparam int CMP_W = (SW > SLOTS_W) ? SW : SLOTS_W;

  logic [SW-1:0]    slots, slots_wr;
  logic [CMP_W-1:0] wr_ext;
  logic             cfg_wr;
  logic             push, pop, q_full, q_empty;
  wroc_job_t        push_job, pop_job;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_WINDOW_SLOTS);
  assign wr_ext = CMP_W'(pwdata[SLOTS_W-1:0]);
  assign prdata = (paddr == ADDR_WINDOW_SLOTS) ? APB_DATA_W'(slots) : '0;

  always_comb begin
    if (wr_ext < CMP_W'(SLOTS_MIN)) begin
      slots_wr = SW'(SLOTS_MIN);
    end else if (wr_ext > CMP_W'(MAX_SLOTS)) begin
      slots_wr = SW'(MAX_SLOTS);
    end else begin
      slots_wr = SW'(wr_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots <= SW'(SLOTS_MIN);
    end else if (cfg_wr) begin
      slots <= slots_wr;
    end
  end

  wroc_front #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .slots          (slots),
    .restart        (cfg_wr),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .sample_time_us (sample_time_us),
    .sample_value   (sample_value),
    .push           (push),
    .push_job       (push_job),
    .q_full         (q_full)
  );

  wroc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  wroc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .pop_job     (pop_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .rate        (rate),
    .rate_zeroed (rate_zeroed)
  );

endmodule

### hw/rtl/wroc_checker.sv
// Port-level checker for windowed_rate_of_change_top, bound to the top level.
// Uses wroc_pkg and windowed_rate_of_change_top_macros.svh.
`include "windowed_rate_of_change_top_macros.svh"

module wroc_checker import wroc_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [RATE_W-1:0] rate,
  input logic              rate_zeroed
);

  localparam int PW = $clog2(MAX_INFLIGHT + 2);

  logic [PW-1:0] pending;
  logic          in_acc, out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // samples taken whose result has not yet been delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_acc && !out_acc) begin
      pending <= PW'(pending + 1'b1);
    end else if (out_acc && !in_acc) begin
      pending <= PW'(pending - 1'b1);
    end
  end

  `WROC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `WROC_ASSERT_NOW(a_zeroed_rate, out_valid && rate_zeroed, rate == '0)
  `WROC_ASSERT_NOW(a_no_spurious, out_valid, pending != '0)
  `WROC_ASSERT_NOW(a_bounded, 1'b1, pending <= PW'(MAX_INFLIGHT))

endmodule

bind windowed_rate_of_change_top wroc_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .rate        (rate),
  .rate_zeroed (rate_zeroed)
);

### verif/tb_windowed_rate_of_change_top.sv
// Testbench for windowed_rate_of_change_top: directed and random samples checked
// against an in-bench window predictor, with APB window_slots writes between phases.
// Depends on wroc_pkg and the windowed_rate_of_change_top RTL.
module tb_windowed_rate_of_change_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wroc_pkg::*;

  localparam int WINDOW_DEPTH = 64;
  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 70;
  localparam longint unsigned RATE_SCALE = 64'(SCALE_MUL) << FRAC_BITS;
  localparam logic [127:0] RATE_MAX = 128'((64'd1 << RATE_W) - 64'd1);
  localparam logic [VAL_W-1:0] VAL_MAX = '1;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic              zeroed;
  } rate_result_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [VAL_W-1:0]      sample_time_us;
  logic [VAL_W-1:0]      sample_value;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [RATE_W-1:0]     rate;
  logic                  rate_zeroed;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // predictor state
  logic [VAL_W-1:0] hist_time [WINDOW_DEPTH];
  logic [VAL_W-1:0] hist_value[WINDOW_DEPTH];
  int unsigned      wr_ptr = 0;
  int unsigned      filled = 0;
  int unsigned      win_slots = SLOTS_MIN;
  logic [VAL_W-1:0] base_time = '0;
  logic [VAL_W-1:0] base_value = '0;

  rate_result_t pending_rates[$];
  int           fail_count = 0;
  int           idle_pct = 35;
  int           stall_pct = 35;
  int           hold_request = 0;
  int           hold_left = 0;
  int           quiet_cycles = 0;

  windowed_rate_of_change_top #(.MAX_SLOTS(WINDOW_DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample_time_us(sample_time_us), .sample_value(sample_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .rate(rate), .rate_zeroed(rate_zeroed),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned clamp_window(input logic [SLOTS_W-1:0] raw);
    if (raw < SLOTS_MIN) return SLOTS_MIN;
    if (raw > WINDOW_DEPTH) return WINDOW_DEPTH;
    return 32'(raw);
  endfunction

  function automatic logic [VAL_W-1:0] rand48();
    return VAL_W'({$urandom(), $urandom()});
  endfunction

  // Push one sample into the window and work out the rate against the oldest entry.
  function automatic rate_result_t advance_window(input logic [VAL_W-1:0] t_now,
                                                  input logic [VAL_W-1:0] v_now);
    rate_result_t     res;
    int unsigned      cur;
    int unsigned      oldest;
    logic [VAL_W-1:0] t_old;
    logic [VAL_W-1:0] v_old;
    logic [VAL_W-1:0] span;
    logic [127:0]     numer;
    logic [127:0]     quot;
    cur = wr_ptr;
    if (filled == 0) begin
      base_time = t_now;
      base_value = v_now;
    end
    hist_time[cur] = t_now;
    hist_value[cur] = v_now;
    wr_ptr = (cur + 1) % WINDOW_DEPTH;
    if (filled < win_slots) filled++;
    // until the window is full the first sample stands in for the oldest
    if (filled < win_slots) begin
      t_old = base_time;
      v_old = base_value;
    end else begin
      oldest = (cur + WINDOW_DEPTH - (win_slots - 1)) % WINDOW_DEPTH;
      t_old = hist_time[oldest];
      v_old = hist_value[oldest];
    end
    span = t_now - t_old;
    if (span == '0 || v_now < v_old) begin
      res.rate = '0;
      res.zeroed = 1'b1;
    end else begin
      numer = 128'(v_now - v_old) * 128'(RATE_SCALE);
      quot = numer / 128'(span);
      res.rate = (quot > RATE_MAX) ? '1 : quot[RATE_W-1:0];
      res.zeroed = 1'b0;
    end
    return res;
  endfunction

  // all tasks start and end just after a falling edge
  task automatic send_sample(input logic [VAL_W-1:0] t, input logic [VAL_W-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    sample_time_us = t;
    sample_value = v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_rates.push_back(advance_window(t, v));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_rates.size() != 0) @(negedge clk);
  endtask

  task automatic write_window_slots(input logic [APB_DATA_W-1:0] word);
    wait_drained();
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = ADDR_WINDOW_SLOTS;
    pwdata = word;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    win_slots = clamp_window(word[SLOTS_W-1:0]);
    filled = 0;
    wr_ptr = 0;
  endtask

  // Mostly rising counters over advancing time, with zero steps, drops,
  // big jumps and fully random samples mixed in.
  task automatic drive_sample_stream(input int count);
    logic [VAL_W-1:0] t;
    logic [VAL_W-1:0] v;
    t = ($urandom_range(3) == 0) ? VAL_MAX - VAL_W'($urandom_range(20000000)) : rand48();
    v = ($urandom_range(1) == 0) ? rand48() : VAL_W'($urandom_range(100000));
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: ;
        1: t = rand48();
        2: t = t + VAL_W'($urandom());
        default: t = t + VAL_W'($urandom_range(1, 2000000));
      endcase
      case ($urandom_range(9))
        0: v = v - VAL_W'($urandom_range(1, 1000));
        1: v = rand48();
        2: v = v + VAL_W'({$urandom_range(65535), $urandom()});
        default: v = v + VAL_W'($urandom_range(500000));
      endcase
      send_sample(t, v);
    end
  endtask

  task automatic test_default_window();
    send_sample(48'd100, 48'd1000);   // first sample is its own oldest: zero span
    send_sample(48'd1100, 48'd2000);
    send_sample(48'd1100, 48'd3000);  // zero span
    send_sample(48'd2100, 48'd2500);  // counter went down
    send_sample(48'd5100, 48'd2500);  // flat counter, rate 0 but not zeroed
  endtask

  task automatic test_field_extremes();
    write_window_slots(32'd2);
    send_sample('0, '0);
    send_sample(48'd1, VAL_MAX);      // saturates
    send_sample(VAL_MAX, VAL_MAX);
    send_sample(VAL_MAX, '0);
    send_sample(48'd9, 48'd5);        // time wraps past 2^48
    send_sample(48'h8000_0000_0000, 48'd6);
    send_sample(48'h8000_000F_4240, 48'd1000006);
  endtask

  task automatic test_window_restart();
    write_window_slots(32'd3);
    send_sample(48'd10, 48'd100);
    send_sample(48'd20, 48'd200);
    send_sample(48'd30, 48'd300);
    send_sample(48'd40, 48'd450);
    send_sample(48'd45, 48'd460);
    write_window_slots(32'd0);        // clamps to the minimum window
    send_sample(48'd50, 48'd10);
    send_sample(48'd70, 48'd30);
    write_window_slots(32'h0000_0185); // only the low bits hold the window length
    send_sample(48'd80, 48'd40);
    send_sample(48'd90, 48'd55);
  endtask

  task automatic test_backpressure();
    write_window_slots(32'd4);
    hold_request = 600;
    drive_sample_stream(12);
  endtask

  task automatic test_random_windows();
    logic [SLOTS_W-1:0] slot_list[8];
    slot_list = '{7'd64, 7'd2, 7'd0, 7'd127, 7'd1, 7'd65, 7'd3, 7'd0};
    slot_list[7] = SLOTS_W'($urandom_range(2, 64));
    for (int p = 0; p < 8; p++) begin
      write_window_slots({25'($urandom_range(32'h1FF_FFFF)), slot_list[p]});
      // first phase runs with no idling on either side
      idle_pct = (p == 0) ? 0 : 35;
      stall_pct = (p == 0) ? 0 : 35;
      drive_sample_stream(80);
    end
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_rate
    rate_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_rates.size() == 0) begin
        $error("unexpected result transaction: rate %0d zeroed %0d", rate, rate_zeroed);
        fail_count++;
      end else begin
        want = pending_rates.pop_front();
        if (rate !== want.rate) begin
          $error("rate: expected %0d, actual %0d", want.rate, rate);
          fail_count++;
        end
        if (rate_zeroed !== want.zeroed) begin
          $error("rate_zeroed: expected %0d, actual %0d", want.zeroed, rate_zeroed);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[windowed_rate_of_change_top] ERROR");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    sample_time_us = '0;
    sample_value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    test_default_window();
    test_field_extremes();
    test_window_restart();
    test_backpressure();
    test_random_windows();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("[windowed_rate_of_change_top] OK");
    else
      $display("[windowed_rate_of_change_top] ERROR");
    $finish;
  end

endmodule

### windowed_rate_of_change_top.f
+incdir+hw/rtl
hw/rtl/wroc_pkg.sv
hw/rtl/wroc_ram.sv
hw/rtl/wroc_front.sv
hw/rtl/wroc_queue.sv
hw/rtl/wroc_back.sv
hw/rtl/windowed_rate_of_change_top.sv
hw/rtl/wroc_checker.sv
verif/tb_windowed_rate_of_change_top.sv
